// File: rtl/core/trp_pkg.sv
package trp_pkg;

  // Widths of the stream payload fields and of the configuration registers.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_W  = 31;

  // Kind of an input request, carried on the slave tuser bit.
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Configuration register indexes.
  localparam logic REG_ACCEL_STEP  = 1'b0;
  localparam logic REG_SPEED_LIMIT = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] ACCEL_STEP_RESET  = 31'd65536;
  localparam logic [CFG_W-1:0] SPEED_LIMIT_RESET = 31'd655360;

  // The stopping distance divider retires one quotient bit per step.
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned STEP_W    = 6;

  // Saturation bounds of a signed 32-bit value.
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_PROBE,
    ST_VEL,
    ST_POS,
    ST_WRITE
  } trp_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_restart;
    logic tick_start;
    logic mul_load;
    logic div_step;
    logic probe;
    logic vel_update;
    logic pos_update;
    logic out_load;
  } trp_cmd_t;

endpackage

// File: rtl/core/trp_ctrl.sv
module trp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tuser,
  output logic                s_axis_tready,
  input  logic                m_axis_tready,
  output logic                m_axis_tvalid,
  output trp_pkg::trp_cmd_t   cmd
);

  localparam logic [trp_pkg::STEP_W-1:0] DIV_LAST = trp_pkg::STEP_W'(trp_pkg::DIV_STEPS - 1);

  trp_pkg::trp_state_t          state;
  trp_pkg::trp_state_t          state_next;
  logic [trp_pkg::STEP_W-1:0]   step_cnt;
  logic                         out_valid;
  logic                         out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free      = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      trp_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == trp_pkg::CMD_RESTART) begin
            state_next = trp_pkg::ST_WRITE;
          end else begin
            state_next = trp_pkg::ST_MUL;
          end
        end
      end
      trp_pkg::ST_MUL:   state_next = trp_pkg::ST_DIV;
      trp_pkg::ST_DIV: begin
        if (step_cnt == DIV_LAST) begin
          state_next = trp_pkg::ST_PROBE;
        end
      end
      trp_pkg::ST_PROBE: state_next = trp_pkg::ST_VEL;
      trp_pkg::ST_VEL:   state_next = trp_pkg::ST_POS;
      trp_pkg::ST_POS:   state_next = trp_pkg::ST_WRITE;
      trp_pkg::ST_WRITE: begin
        if (out_free) begin
          state_next = trp_pkg::ST_IDLE;
        end
      end
      default:           state_next = trp_pkg::ST_IDLE;
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      trp_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load_restart = (s_axis_tuser == trp_pkg::CMD_RESTART);
          cmd.tick_start   = (s_axis_tuser == trp_pkg::CMD_TICK);
        end
      end
      trp_pkg::ST_MUL:   cmd.mul_load   = 1'b1;
      trp_pkg::ST_DIV:   cmd.div_step   = 1'b1;
      trp_pkg::ST_PROBE: cmd.probe      = 1'b1;
      trp_pkg::ST_VEL:   cmd.vel_update = 1'b1;
      trp_pkg::ST_POS:   cmd.pos_update = 1'b1;
      trp_pkg::ST_WRITE: cmd.out_load   = out_free;
      default:           cmd            = '0;
    endcase
  end

  // State register and divider step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= trp_pkg::ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == trp_pkg::ST_DIV) begin
        step_cnt <= step_cnt + 1'b1;
      end else begin
        step_cnt <= '0;
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/core/trp_datapath.sv
module trp_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  trp_pkg::trp_cmd_t                   cmd,
  input  logic signed [trp_pkg::DATA_W-1:0]   new_target,
  input  logic                                cfg_we,
  input  logic                                cfg_addr,
  input  logic [trp_pkg::CFG_W-1:0]           cfg_wdata,
  output logic signed [trp_pkg::DATA_W-1:0]   position_out,
  output logic signed [trp_pkg::DATA_W-1:0]   velocity_out
);

  logic [trp_pkg::CFG_W-1:0]           accel_step;
  logic [trp_pkg::CFG_W-1:0]           speed_limit;
  logic signed [trp_pkg::DATA_W-1:0]   target_pos;
  logic signed [trp_pkg::DATA_W-1:0]   ramp_pos;
  logic signed [trp_pkg::DATA_W-1:0]   ramp_vel;
  logic [31:0]                         mag;
  logic [31:0]                         divisor;
  logic [63:0]                         quo;
  logic [31:0]                         rem;
  logic                                rise;

  logic [trp_pkg::CFG_W-1:0]           accel_eff;
  logic [32:0]                         rem_sh;
  logic                                fits;
  logic signed [63:0]                  stop_dist;
  logic signed [63:0]                  probe_sum;
  logic signed [31:0]                  probe;
  logic signed [33:0]                  vel_wide;
  logic signed [33:0]                  accel_wide;
  logic signed [33:0]                  lim_wide;
  logic signed [33:0]                  nv;
  logic signed [33:0]                  nv_clamped;
  logic signed [31:0]                  vel_next;
  logic signed [32:0]                  pos_sum;
  logic signed [31:0]                  pos_next;

  // A zero acceleration divides as if the acceleration were one.
  assign accel_eff = (accel_step == '0) ? trp_pkg::CFG_W'(1) : accel_step;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_step  <= trp_pkg::ACCEL_STEP_RESET;
      speed_limit <= trp_pkg::SPEED_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        trp_pkg::REG_ACCEL_STEP:  accel_step  <= cfg_wdata;
        trp_pkg::REG_SPEED_LIMIT: speed_limit <= cfg_wdata;
      endcase
    end
  end

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh = {rem, quo[63]};
  assign fits   = (rem_sh >= {1'b0, divisor});

  // Stopping distance carries the velocity sign; the probe saturates to 32 bits.
  assign stop_dist = ramp_vel[31] ? -$signed(quo) : $signed(quo);
  assign probe_sum = {{32{ramp_pos[31]}}, ramp_pos} + stop_dist;
  always_comb begin
    if (!probe_sum[63] && (|probe_sum[62:31])) begin
      probe = trp_pkg::VAL_MAX;
    end else if (probe_sum[63] && !(&probe_sum[62:31])) begin
      probe = trp_pkg::VAL_MIN;
    end else begin
      probe = probe_sum[31:0];
    end
  end

  // Velocity step with a one-sided clamp, then saturation to 32 bits.
  assign vel_wide   = {{2{ramp_vel[31]}}, ramp_vel};
  assign accel_wide = {3'b000, accel_step};
  assign lim_wide   = {3'b000, speed_limit};
  assign nv         = rise ? (vel_wide + accel_wide) : (vel_wide - accel_wide);
  always_comb begin
    nv_clamped = nv;
    if (rise && (nv > lim_wide)) begin
      nv_clamped = lim_wide;
    end else if (!rise && (nv < -lim_wide)) begin
      nv_clamped = -lim_wide;
    end
    if (nv_clamped > 34'(trp_pkg::VAL_MAX)) begin
      vel_next = trp_pkg::VAL_MAX;
    end else if (nv_clamped < 34'(trp_pkg::VAL_MIN)) begin
      vel_next = trp_pkg::VAL_MIN;
    end else begin
      vel_next = nv_clamped[31:0];
    end
  end

  // Position integrates the new velocity with saturation.
  assign pos_sum = {ramp_pos[31], ramp_pos} + {ramp_vel[31], ramp_vel};
  always_comb begin
    if (pos_sum[32] != pos_sum[31]) begin
      pos_next = pos_sum[32] ? trp_pkg::VAL_MIN : trp_pkg::VAL_MAX;
    end else begin
      pos_next = pos_sum[31:0];
    end
  end

  // Ramp state.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_pos <= '0;
      ramp_pos   <= '0;
      ramp_vel   <= '0;
    end else if (cmd.load_restart) begin
      target_pos <= new_target;
      ramp_pos   <= new_target;
      ramp_vel   <= '0;
    end else if (cmd.vel_update) begin
      ramp_vel <= vel_next;
    end else if (cmd.pos_update) begin
      ramp_pos <= pos_next;
    end
  end

  // Square, divider and probe registers.
  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      mag     <= ramp_vel[31] ? 32'(-ramp_vel) : 32'(ramp_vel);
      divisor <= {accel_eff, 1'b0};
    end
    if (cmd.mul_load) begin
      quo <= mag * mag;
      rem <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[62:0], fits};
      rem <= fits ? 32'(rem_sh - {1'b0, divisor}) : rem_sh[31:0];
    end
    if (cmd.probe) begin
      rise <= (probe < target_pos);
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      position_out <= ramp_pos;
      velocity_out <= ramp_vel;
    end
  end

endmodule

// File: rtl/core/trapezoidal_position_ramp_top.sv
// Trapezoidal position ramp generator, Q16.16 in units per control tick. A restart
// request (tuser = 1) jumps position and target to tdata and zeroes velocity; its result
// is handed to the output register once that register is free. A tick request (tuser = 0)
// computes the stopping distance v*v/(2*a), accelerates toward the target or brakes,
// clamps at the speed limit and integrates the position. Its steps are, in order, the
// acceptance, the square, the 64-step restoring divider that forms the stopping distance,
// the target compare, the velocity update, the position update and the result handoff.
// One request is worked at a time; the next request is taken once the previous result
// has moved into the output register, even if that result is still waiting downstream.
// Write the configuration registers only while no request is in flight.
module trapezoidal_position_ramp_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // [31:0] new_target
  input  logic [0:0]   s_axis_tuser,   // [0] command
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // [31:0] position_out, [63:32] velocity_out
  input  logic         cfg_we,
  input  logic [0:0]   cfg_addr,
  input  logic [30:0]  cfg_wdata
);

  trp_pkg::trp_cmd_t                   cmd;
  logic signed [trp_pkg::DATA_W-1:0]   position_out;
  logic signed [trp_pkg::DATA_W-1:0]   velocity_out;

  // Sequencer.
  trp_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tuser  (s_axis_tuser[0]),
    .s_axis_tready (s_axis_tready),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .cmd           (cmd)
  );

  // Arithmetic and state.
  trp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .new_target   ($signed(s_axis_tdata)),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr[0]),
    .cfg_wdata    (cfg_wdata),
    .position_out (position_out),
    .velocity_out (velocity_out)
  );

  assign m_axis_tdata = {velocity_out, position_out};

endmodule

// File: rtl/core/trp_checker.sv
module trp_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [31:0]  s_axis_tdata,
  input logic [0:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [63:0]  m_axis_tdata
);

  // No result is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // Only one request is in flight: the block is busy right after an acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while busy");

  // A restart with an empty output yields position = target and zero velocity.
  a_restart_result: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] && !m_axis_tvalid)
      |=> ##1 (m_axis_tvalid && (m_axis_tdata[31:0] == $past(s_axis_tdata, 2))
               && (m_axis_tdata[63:32] == 32'd0)))
    else $error("restart result wrong");

endmodule

bind trapezoidal_position_ramp_top trp_checker u_trp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: dv/trapezoidal_position_ramp_checker.sv
module trapezoidal_position_ramp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] new_target
  input  logic [0:0]  s_axis_tuser,   // [0] command
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,   // [31:0] position_out, [63:32] velocity_out
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [30:0] cfg_wdata,
  input  logic        wrap_up,
  output int unsigned mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
  } ramp_sample_t;

  // Shadow copy of the ramp state and of the two configuration registers.
  logic signed [31:0] goal;
  logic signed [31:0] cur_pos;
  logic signed [31:0] cur_vel;
  logic [30:0]        accel_cfg;
  logic [30:0]        vmax_cfg;

  // Position and velocity that each accepted request should produce, oldest first.
  ramp_sample_t ramp_expected_q[$];

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("%0t ns ramp check: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic signed [31:0] sat_q(input longint x);
    if (x > 64'sd2147483647) return 32'sh7fff_ffff;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return 32'(x);
  endfunction

  // Advance the shadow ramp by one request and queue the sample it yields.
  task automatic advance_ramp(input logic cmd, input logic [31:0] tgt);
    longint v, mag, divisor, stop_dist, step, vlim, nv;
    logic signed [31:0] probe;
    if (cmd == trp_pkg::CMD_RESTART) begin
      goal    = tgt;
      cur_pos = tgt;
      cur_vel = '0;
    end else begin
      v       = cur_vel;
      mag     = (v < 0) ? -v : v;
      step    = accel_cfg;
      vlim    = vmax_cfg;
      // A zero acceleration still divides as if it were one.
      divisor = (step == 0) ? 2 : 2 * step;
      stop_dist = (mag * mag) / divisor;
      if (v < 0) stop_dist = -stop_dist;
      probe = sat_q(longint'(cur_pos) + stop_dist);
      // Each direction is clamped only on its own side.
      if (probe < goal) begin
        nv = v + step;
        if (nv > vlim) nv = vlim;
      end else begin
        nv = v - step;
        if (nv < -vlim) nv = -vlim;
      end
      cur_vel = sat_q(nv);
      cur_pos = sat_q(longint'(cur_pos) + longint'(cur_vel));
    end
    ramp_expected_q.push_back('{pos: cur_pos, vel: cur_vel});
  endtask

  // Results are checked before a request of the same edge is predicted.
  always @(posedge clk) begin
    ramp_sample_t want;
    if (rst) begin
      goal       = '0;
      cur_pos    = '0;
      cur_vel    = '0;
      accel_cfg  = trp_pkg::ACCEL_STEP_RESET;
      vmax_cfg   = trp_pkg::SPEED_LIMIT_RESET;
      mismatches = 0;
      ramp_expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          trp_pkg::REG_ACCEL_STEP:  accel_cfg = cfg_wdata;
          trp_pkg::REG_SPEED_LIMIT: vmax_cfg  = cfg_wdata;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (ramp_expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result pos %h vel %h",
                                    m_axis_tdata[31:0], m_axis_tdata[63:32]));
        end else begin
          want = ramp_expected_q.pop_front();
          if (m_axis_tdata[31:0] !== want.pos)
            report_mismatch($sformatf("position_out %h, predicted %h",
                                      m_axis_tdata[31:0], want.pos));
          if (m_axis_tdata[63:32] !== want.vel)
            report_mismatch($sformatf("velocity_out %h, predicted %h",
                                      m_axis_tdata[63:32], want.vel));
        end
      end
      if (s_axis_tvalid && s_axis_tready) advance_ramp(s_axis_tuser[0], s_axis_tdata);
      // Anything still queued once the run winds down never came out.
      if (wrap_up && ramp_expected_q.size() != 0) begin
        report_mismatch($sformatf("%0d results never arrived", ramp_expected_q.size()));
        ramp_expected_q.delete();
      end
    end
  end

endmodule

// File: dv/trapezoidal_position_ramp_top_tb.sv
module trapezoidal_position_ramp_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS = 240;
  localparam int unsigned NUM_PHASES  = 8;
  localparam logic [30:0] CFG_MAX     = 31'h7fff_ffff;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic [31:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tready = 1'b0;
  logic        cfg_we        = 1'b0;
  logic [0:0]  cfg_addr      = '0;
  logic [30:0] cfg_wdata     = '0;
  logic        wrap_up       = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [63:0] m_axis_tdata;

  int unsigned mismatches;
  int unsigned n_sent       = 0;
  int unsigned n_recv       = 0;
  int unsigned quiet_cycles = 0;

  // Sender pacing: bursts of requests separated by idle gaps.
  int unsigned burst_left = 0;
  int unsigned gap_max    = 8;
  bit          gaps_on    = 1'b0;
  int unsigned ticks_left = 0;

  // Receiver pacing: 0 is always ready, 1 a random pattern, 2 a sparse one.
  logic [1:0]  ready_mode  = 2'd0;
  logic [15:0] stall_pat   = 16'hffff;
  logic [3:0]  stall_phase = '0;

  always #6 clk = ~clk;

  trapezoidal_position_ramp_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  trapezoidal_position_ramp_checker ramp_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .wrap_up       (wrap_up),
    .mismatches    (mismatches)
  );

  // The ready pattern is refreshed each time the 4-bit phase counter wraps and rotated in between.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 4'd1;
    if (stall_phase == '0)
      stall_pat <= (ready_mode == 2'd2) ? 16'($urandom & $urandom) : 16'($urandom);
    else
      stall_pat <= {stall_pat[0], stall_pat[15:1]};
    m_axis_tready <= (ready_mode == 2'd0) ? 1'b1 : stall_pat[0];
  end

  // Request and result counts, plus the number of cycles since the last handshake.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) n_sent <= n_sent + 1;
      if (m_axis_tvalid && m_axis_tready) n_recv <= n_recv + 1;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request and hold it until the block takes it.
  task automatic send_req(input logic cmd, input logic [31:0] tgt);
    if (burst_left == 0) begin
      if (gaps_on) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= tgt;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop sending and wait until every request has produced its result.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (n_recv != n_sent) @(posedge clk);
  endtask

  // Both registers are rewritten on every change; the block must be idle.
  task automatic set_config(input logic [30:0] accel, input logic [30:0] vmax);
    cfg_we    <= 1'b1;
    cfg_addr  <= trp_pkg::REG_ACCEL_STEP;
    cfg_wdata <= accel;
    @(posedge clk);
    cfg_addr  <= trp_pkg::REG_SPEED_LIMIT;
    cfg_wdata <= vmax;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_target();
    case ($urandom_range(0, 5))
      0:       return 32'h7fff_ffff - $urandom_range(0, 1 << 20);
      1:       return 32'h8000_0000 + $urandom_range(0, 1 << 20);
      2:       return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    logic [30:0] acc_v;
    logic [30:0] lim_v;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset configuration: zero state, both extremes of the
    // target with position saturation, and an ordinary target either side of zero.
    send_req(trp_pkg::CMD_TICK, 32'h0);
    send_req(trp_pkg::CMD_RESTART, 32'h7fff_ffff);
    send_req(trp_pkg::CMD_TICK, 32'h0);
    send_req(trp_pkg::CMD_TICK, 32'hffff_ffff);
    send_req(trp_pkg::CMD_RESTART, 32'h8000_0000);
    send_req(trp_pkg::CMD_TICK, 32'h0);
    send_req(trp_pkg::CMD_TICK, 32'h0);
    send_req(trp_pkg::CMD_RESTART, 32'h0064_0000);
    send_req(trp_pkg::CMD_TICK, 32'h0);
    send_req(trp_pkg::CMD_TICK, 32'h0);
    send_req(trp_pkg::CMD_TICK, 32'h0);
    send_req(trp_pkg::CMD_RESTART, 32'hfff0_0000);
    send_req(trp_pkg::CMD_TICK, 32'h0);

    // Build up a large velocity with a big step.
    wait_idle();
    set_config(31'd1 << 24, CFG_MAX);
    send_req(trp_pkg::CMD_RESTART, 32'h0);
    send_req(trp_pkg::CMD_TICK, 32'h0);
    send_req(trp_pkg::CMD_TICK, 32'h0);
    send_req(trp_pkg::CMD_TICK, 32'h0);

    // A smaller step and limit leave it above the limit: it decays step by step
    // while the stopping distance saturates the probe.
    wait_idle();
    set_config(31'd65536, 31'd262144);
    repeat (4) send_req(trp_pkg::CMD_TICK, 32'h0);

    // Zero acceleration, then a zero speed limit.
    wait_idle();
    set_config(31'd0, 31'd655360);
    send_req(trp_pkg::CMD_TICK, 32'h0);
    send_req(trp_pkg::CMD_TICK, 32'h0);
    wait_idle();
    set_config(31'd1, 31'd0);
    send_req(trp_pkg::CMD_TICK, 32'h0);
    send_req(trp_pkg::CMD_RESTART, 32'h0000_0005);

    // Random part: restarts followed by runs of ticks, a few cut short.
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin acc_v = 31'd1;     lim_v = CFG_MAX; end
        1: begin acc_v = CFG_MAX;   lim_v = CFG_MAX; end
        2: begin acc_v = 31'd0;     lim_v = 31'($urandom_range(0, 1 << 24)); end
        3: begin acc_v = 31'($urandom_range(1, 1 << 20)); lim_v = 31'd0; end
        default: begin
          case ($urandom_range(0, 2))
            0:       acc_v = 31'($urandom_range(1, 1 << 16));
            1:       acc_v = 31'($urandom_range(1, 1 << 24));
            default: acc_v = 31'($urandom);
          endcase
          case ($urandom_range(0, 2))
            0:       lim_v = 31'($urandom_range(0, 1 << 20));
            1:       lim_v = 31'($urandom_range(0, 1 << 26));
            default: lim_v = 31'($urandom);
          endcase
        end
      endcase
      set_config(acc_v, lim_v);
      gaps_on    = (p % 3 != 0);
      gap_max    = (p % 2 == 1) ? 90 : 8;
      ready_mode <= 2'(p % 3);
      ticks_left = $urandom_range(1, 20);
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 4 && k == PHASE_ITEMS / 2) wait_idle();
        if (ticks_left == 0 || $urandom_range(0, 49) == 0) begin
          send_req(trp_pkg::CMD_RESTART, pick_target());
          ticks_left = $urandom_range(1, 40);
        end else begin
          send_req(trp_pkg::CMD_TICK, $urandom);
          ticks_left--;
        end
      end
    end

    // Drain, flag anything left over, and watch for stray results.
    wait_idle();
    wrap_up <= 1'b1;
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("trapezoidal_position_ramp_top: match");
    end else begin
      $display("trapezoidal_position_ramp_top: mismatch");
    end
    $finish;
  end

  // A long stretch with no handshake on either stream means the block hung.
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("trapezoidal_position_ramp_top: mismatch");
    $finish;
  end

endmodule
